// ===== hdl/sft_pkg.sv =====
package sft_pkg;

  localparam int MAX_WORD_DEF      = 16;
  localparam int MAX_STOPWORDS_DEF = 64;
  localparam int POS_BITS_DEF      = 24;

  localparam int OP_W   = 2;
  localparam int CHAR_W = 8;
  localparam int OUT_W  = 24;
  localparam int BS_W   = 16;
  localparam int CFG_IW = 1;

  typedef logic [OP_W-1:0] op_t;

  localparam op_t OP_STOP_CHAR = 2'd0;
  localparam op_t OP_DOC_CHAR  = 2'd1;
  localparam op_t OP_STOP_END  = 2'd2;
  localparam op_t OP_DOC_END   = 2'd3;

  localparam logic [CFG_IW-1:0] REG_ADDRESS_MODE = 1'd0;
  localparam logic [CFG_IW-1:0] REG_BLOCK_SIZE   = 1'd1;

  localparam logic [BS_W-1:0] BLOCK_SIZE_RESET = 16'd5;

  typedef struct packed {
    logic in_ready;
    logic capture;
    logic take;
    logic set_start;
    logic advance;
    logic reset_pos;
    logic clear_word;
    logic div_start;
    logic div_step;
    logic k_clr;
    logic k_inc;
    logic i_clr;
    logic i_inc;
    logic store_wr;
    logic store_done;
    logic emit;
  } sft_cmd_t;

  typedef struct packed {
    logic in_valid;
    op_t  op;
    logic delim;
    logic len_zero;
    logic count_full;
    logic count_zero;
    logic need_div;
    logic div_last;
    logic len_match;
    logic char_match;
    logic k_last;
    logic i_last;
    logic out_free;
  } sft_sts_t;

  function automatic logic is_delim(input logic [CHAR_W-1:0] c);
    return (c == 8'h20) || (c == 8'h2e) || (c == 8'h0a);
  endfunction

endpackage

// ===== hdl/sft_in_if.sv =====
interface sft_in_if;
  import sft_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [CHAR_W-1:0] character;
  modport source (output valid, opcode, character, input ready);
  modport sink (input valid, opcode, character, output ready);
endinterface

// ===== hdl/sft_out_if.sv =====
interface sft_out_if;
  import sft_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] word_char;
  logic [OUT_W-1:0]  word_offset;
  logic [OUT_W-1:0]  word_block;
  logic              truncated;
  logic              last_char;
  modport source (output valid, word_char, word_offset, word_block, truncated, last_char,
                  input ready);
  modport sink (input valid, word_char, word_offset, word_block, truncated, last_char,
                output ready);
endinterface

// ===== hdl/sft_cfg_if.sv =====
interface sft_cfg_if;
  import sft_pkg::*;
  logic              valid;
  logic              ready;
  logic [CFG_IW-1:0] index;
  logic [BS_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/sft_ctrl.sv =====
module sft_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  sft_pkg::sft_sts_t sts,
  output sft_pkg::sft_cmd_t cmd
);
  import sft_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_DIV   = 4'd2;
  localparam logic [3:0] S_STORE = 4'd3;
  localparam logic [3:0] S_LRD   = 4'd4;
  localparam logic [3:0] S_LCMP  = 4'd5;
  localparam logic [3:0] S_CRD   = 4'd6;
  localparam logic [3:0] S_CCMP  = 4'd7;
  localparam logic [3:0] S_EMIT  = 4'd8;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts.op) inside
          OP_STOP_CHAR, OP_STOP_END: begin
            if (sts.op == OP_STOP_END) cmd.reset_pos = 1'b1;
            if (sts.op == OP_STOP_CHAR && !sts.delim) begin
              cmd.take   = 1'b1;
              state_next = S_IDLE;
            end else if (!sts.len_zero && !sts.count_full) begin
              cmd.k_clr  = 1'b1;
              state_next = S_STORE;
            end else begin
              cmd.clear_word = 1'b1;
              state_next     = S_IDLE;
            end
          end
          OP_DOC_CHAR, OP_DOC_END: begin
            if (sts.op == OP_DOC_CHAR && sts.need_div) begin
              cmd.div_start = 1'b1;
              state_next    = S_DIV;
            end else begin
              if (sts.op == OP_DOC_END) cmd.reset_pos = 1'b1;
              else                      cmd.advance   = 1'b1;
              if (sts.op == OP_DOC_CHAR && !sts.delim) begin
                cmd.set_start = sts.len_zero;
                cmd.take      = 1'b1;
                state_next    = S_IDLE;
              end else if (sts.len_zero) begin
                cmd.clear_word = 1'b1;
                state_next     = S_IDLE;
              end else begin
                cmd.i_clr  = 1'b1;
                cmd.k_clr  = 1'b1;
                state_next = sts.count_zero ? S_EMIT : S_LRD;
              end
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = S_DISP;
      end
      S_STORE: begin
        cmd.store_wr = 1'b1;
        cmd.k_inc    = 1'b1;
        if (sts.k_last) begin
          cmd.store_done = 1'b1;
          cmd.clear_word = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_LRD: state_next = S_LCMP;
      S_LCMP: begin
        if (sts.len_match) begin
          cmd.k_clr  = 1'b1;
          state_next = S_CRD;
        end else if (sts.i_last) begin
          cmd.k_clr  = 1'b1;
          state_next = S_EMIT;
        end else begin
          cmd.i_inc  = 1'b1;
          state_next = S_LRD;
        end
      end
      S_CRD: state_next = S_CCMP;
      S_CCMP: begin
        if (!sts.char_match) begin
          if (sts.i_last) begin
            cmd.k_clr  = 1'b1;
            state_next = S_EMIT;
          end else begin
            cmd.i_inc  = 1'b1;
            state_next = S_LRD;
          end
        end else if (sts.k_last) begin
          // stopword hit: drop the word
          cmd.clear_word = 1'b1;
          state_next     = S_IDLE;
        end else begin
          cmd.k_inc  = 1'b1;
          state_next = S_CRD;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.k_inc = 1'b1;
          if (sts.k_last) begin
            cmd.clear_word = 1'b1;
            state_next     = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== hdl/sft_datapath.sv =====
module sft_datapath #(
  parameter int MAX_WORD      = sft_pkg::MAX_WORD_DEF,
  parameter int MAX_STOPWORDS = sft_pkg::MAX_STOPWORDS_DEF,
  parameter int POS_BITS      = sft_pkg::POS_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  sft_pkg::sft_cmd_t cmd,
  output sft_pkg::sft_sts_t sts,
  sft_in_if.sink            chars,
  sft_out_if.source         words,
  sft_cfg_if.sink           cfg
);
  import sft_pkg::*;

  localparam int LEN_W  = $clog2(MAX_WORD + 1);
  localparam int WI_W   = $clog2(MAX_WORD);
  localparam int CNT_W  = $clog2(MAX_STOPWORDS + 1);
  localparam int SW_IW  = (MAX_STOPWORDS > 1) ? $clog2(MAX_STOPWORDS) : 1;
  localparam int DEPTH  = MAX_STOPWORDS * MAX_WORD;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int DC_W   = $clog2(POS_BITS);
  localparam int CW     = (POS_BITS > BS_W) ? POS_BITS : BS_W;
  localparam int CW1    = CW + 1;

  // configuration
  logic            address_mode;
  logic [BS_W-1:0] block_size;
  logic [BS_W-1:0] bs;

  assign cfg.ready = 1'b1;
  assign bs = (block_size == '0) ? BS_W'(1) : block_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      address_mode <= 1'b0;
      block_size   <= BLOCK_SIZE_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_ADDRESS_MODE: address_mode <= cfg.data[0];
        REG_BLOCK_SIZE:   block_size   <= cfg.data;
        default: ;
      endcase
    end
  end

  // captured request
  op_t               op;
  logic [CHAR_W-1:0] ch;

  assign chars.ready = cmd.in_ready;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op <= chars.opcode;
      ch <= chars.character;
    end
  end

  // word buffer
  logic [CHAR_W-1:0] wbuf [MAX_WORD];
  logic [LEN_W-1:0]  word_length;
  logic              word_cut;
  logic [LEN_W-1:0]  k;
  logic [CNT_W-1:0]  i;
  logic [CNT_W-1:0]  stop_count;
  logic [CHAR_W-1:0] buf_k;

  assign buf_k = wbuf[k[WI_W-1:0]];

  always_ff @(posedge clk) begin
    if (cmd.take && word_length < LEN_W'(MAX_WORD)) wbuf[word_length[WI_W-1:0]] <= ch;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_length <= '0;
      word_cut    <= 1'b0;
      stop_count  <= '0;
    end else begin
      if (cmd.clear_word) begin
        word_length <= '0;
        word_cut    <= 1'b0;
      end else if (cmd.take) begin
        if (word_length < LEN_W'(MAX_WORD)) word_length <= word_length + 1'b1;
        else                                word_cut    <= 1'b1;
      end
      if (cmd.store_done) stop_count <= stop_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.k_clr)      k <= '0;
    else if (cmd.k_inc) k <= k + 1'b1;
    if (cmd.i_clr)      i <= '0;
    else if (cmd.i_inc) i <= i + 1'b1;
  end

  // stopword table
  logic [CHAR_W-1:0] stop_chars   [DEPTH];
  logic [LEN_W-1:0]  stop_lengths [MAX_STOPWORDS];
  logic [CHAR_W-1:0] char_q;
  logic [LEN_W-1:0]  len_q;
  logic [CNT_W-1:0]  row;
  logic [ADDR_W-1:0] addr;

  assign row  = cmd.store_wr ? stop_count : i;
  assign addr = ADDR_W'(row) * ADDR_W'(MAX_WORD) + ADDR_W'(k);

  always_ff @(posedge clk) begin
    if (cmd.store_wr) stop_chars[addr] <= buf_k;
    char_q <= stop_chars[addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.store_done) stop_lengths[stop_count[SW_IW-1:0]] <= word_length;
    len_q <= stop_lengths[i[SW_IW-1:0]];
  end

  // position counters
  logic [POS_BITS-1:0] offset_count, block_count;
  logic [POS_BITS-1:0] start_offset, start_block;
  logic [CW1-1:0]      off_inc;
  logic                off_wrap;
  logic [POS_BITS-1:0] dq, dq_new;
  logic [BS_W-1:0]     rem, rem_new;
  logic [BS_W:0]       rem_sh;
  logic                ge;
  logic [DC_W-1:0]     div_cnt;

  assign off_inc  = CW1'(offset_count) + 1'b1;
  assign off_wrap = off_inc >= CW1'(bs);

  // one quotient bit per step
  assign rem_sh  = {rem, dq[POS_BITS-1]};
  assign ge      = rem_sh >= {1'b0, bs};
  assign rem_new = ge ? BS_W'(rem_sh - {1'b0, bs}) : rem_sh[BS_W-1:0];
  assign dq_new  = {dq[POS_BITS-2:0], ge};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dq      <= offset_count;
      rem     <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      dq      <= dq_new;
      rem     <= rem_new;
      div_cnt <= div_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_count <= '0;
      block_count  <= '0;
      start_offset <= '0;
      start_block  <= '0;
    end else begin
      if (cmd.set_start) begin
        start_offset <= offset_count;
        start_block  <= address_mode ? block_count : '0;
      end
      if (cmd.reset_pos) begin
        offset_count <= '0;
        block_count  <= '0;
      end else if (cmd.div_step && div_cnt == DC_W'(POS_BITS - 1)) begin
        // fold the quotient into the block number
        offset_count <= POS_BITS'(rem_new);
        block_count  <= block_count + dq_new;
      end else if (cmd.advance) begin
        if (!address_mode) begin
          offset_count <= offset_count + 1'b1;
        end else if (off_wrap) begin
          offset_count <= '0;
          block_count  <= block_count + 1'b1;
        end else begin
          offset_count <= POS_BITS'(off_inc);
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst)              words.valid <= 1'b0;
    else if (cmd.emit)    words.valid <= 1'b1;
    else if (words.ready) words.valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      words.word_char   <= buf_k;
      words.word_offset <= OUT_W'(start_offset);
      words.word_block  <= OUT_W'(start_block);
      words.truncated   <= word_cut;
      words.last_char   <= (k + 1'b1 == word_length);
    end
  end

  always_comb begin
    sts            = '0;
    sts.in_valid   = chars.valid;
    sts.op         = op;
    sts.delim      = is_delim(ch);
    sts.len_zero   = (word_length == '0);
    sts.count_full = (stop_count == CNT_W'(MAX_STOPWORDS));
    sts.count_zero = (stop_count == '0);
    sts.need_div   = address_mode && (CW'(offset_count) >= CW'(bs));
    sts.div_last   = (div_cnt == DC_W'(POS_BITS - 1));
    sts.len_match  = (len_q == word_length);
    sts.char_match = (char_q == buf_k);
    sts.k_last     = (k + 1'b1 == word_length);
    sts.i_last     = (i + 1'b1 == stop_count);
    sts.out_free   = !words.valid || words.ready;
  end

endmodule

// ===== hdl/stopword_filtered_tokenizer_unit.sv =====
// Channel  Dir  Payload                                           Handshake
// chars    in   opcode, character                                 valid/ready
// words    out  word_char, word_offset, word_block,               valid/ready
//               truncated, last_char
// cfg      in   index (0 address_mode, 1 block_size), data        valid/ready
//
// A character passes S_IDLE and S_DISP; when block mode must fold a large
// offset into the block number, S_DIV steps it, one quotient bit a cycle.
// A word end scans the stopword table (length, then characters), one port of
// the table memory per cycle; then emits one character per cycle unless the
// word is a stopword, held while words.ready is low. A stopword is stored one
// character per cycle. Reset is synchronous; the table needs no clearing.
module stopword_filtered_tokenizer_unit #(
  parameter int MAX_WORD      = sft_pkg::MAX_WORD_DEF,
  parameter int MAX_STOPWORDS = sft_pkg::MAX_STOPWORDS_DEF,
  parameter int POS_BITS      = sft_pkg::POS_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  sft_in_if.sink    chars,
  sft_out_if.source words,
  sft_cfg_if.sink   cfg
);
  import sft_pkg::*;

  sft_cmd_t cmd;
  sft_sts_t sts;

  sft_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  sft_datapath #(
    .MAX_WORD      (MAX_WORD),
    .MAX_STOPWORDS (MAX_STOPWORDS),
    .POS_BITS      (POS_BITS)
  ) u_datapath (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .sts   (sts),
    .chars (chars),
    .words (words),
    .cfg   (cfg)
  );

endmodule
